### rtl/cpts_pkg.sv
package cpts_pkg;

   // table size default and fixed field widths
   localparam int NUM_TASKS_DEF = 64;
   localparam int TASK_W        = 6;

   // opcodes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_SCHED = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // run states
   localparam logic [2:0] RS_RUNNING       = 3'd0;
   localparam logic [2:0] RS_INTERRUPTIBLE = 3'd1;

   // alarm signal (14) and the signals that can never be blocked (kill 9, stop 19)
   localparam logic [31:0] SIG_ALRM_BIT = 32'h0000_2000;
   localparam logic [31:0] UNBLOCKABLE  = 32'h0004_0100;

   typedef struct packed {
      logic        present;
      logic [2:0]  run_state;
      logic [7:0]  slice;
      logic [6:0]  prio;
      logic [31:0] alarm;
      logic [31:0] pending;
      logic [31:0] blocked;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      present:   1'b0,
      run_state: 3'd0,
      slice:     8'd0,
      prio:      7'd1,
      alarm:     32'd0,
      pending:   32'd0,
      blocked:   32'd0
   };

   // result beat, last field in the lowest bits
   typedef struct packed {
      logic [31:0] read_pending;
      logic [7:0]  read_slice;
      logic [2:0]  read_state;
      logic        recalculated;
      logic [7:0]  chosen_slice;
      logic [5:0]  next_task;
   } res_type;

endpackage

### rtl/counter_priority_task_scheduler_core.sv
// Counter-priority task scheduler core.
// Request channel (req_*): one beat carries an opcode in tuser (write entry, schedule
// decision, read entry) and the entry fields plus the tick time in tdata.
// Response channel (rsp_*): exactly one beat per request. Write and undefined opcodes
// return all zeros; a read returns state, counter and pending mask of the entry; a
// schedule returns the chosen task, its counter and whether counters were recomputed.
// The task table sits in a single-port-write, single-read RAM with a registered read.
// A schedule decision walks the table from the top entry down to entry 1 through one
// shared update/compare datapath, one entry per cycle: alarm expiry, wake-up and the
// best-counter pick happen in the same walk. If the best counter is zero a second walk
// recomputes counter/2 + priority and picks again.
// The block takes one request at a time; a schedule blocks new ones for its table walk.
// A new request is accepted while the previous response waits in the output register;
// if the receiver stalls, the finished result is held until the output register frees.
// Reset (synchronous, active high) clears the per-entry valid bits at once, so every
// entry reads as its reset value (priority 1, all else zero); no clearing pass is needed.
module counter_priority_task_scheduler_core #(
   parameter int NUM_TASKS = cpts_pkg::NUM_TASKS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: task_index[5:0], present[6], run_state[9:7], slice_count[17:10],
   //        prio[24:18], alarm_time[56:25], pending_mask[88:57],
   //        blocked_mask[120:89], now[152:121], zero fill to 160
   input  logic [159:0] req_tdata,
   // tuser: opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: next_task[5:0], chosen_slice[13:6], recalculated[14], read_state[17:15],
   //        read_slice[25:18], read_pending[57:26], zero fill to 64
   output logic [63:0]  rsp_tdata
);
   import cpts_pkg::*;

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int AW    = ((IDX_W > TASK_W) ? IDX_W : TASK_W) + 1;
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(NUM_TASKS - 1);
   localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_PASS = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   // request fields
   logic [5:0]  req_index;
   logic [31:0] req_now;
   entry_type   req_entry;
   logic        req_beat;

   assign req_index           = req_tdata[5:0];
   assign req_entry.present   = req_tdata[6];
   assign req_entry.run_state = req_tdata[9:7];
   assign req_entry.slice     = req_tdata[17:10];
   assign req_entry.prio      = req_tdata[24:18];
   assign req_entry.alarm     = req_tdata[56:25];
   assign req_entry.pending   = req_tdata[88:57];
   assign req_entry.blocked   = req_tdata[120:89];
   assign req_now             = req_tdata[152:121];
   assign req_beat            = req_tvalid & req_tready;

   // control and payload registers
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             recalc_ff, recalc_in;
   logic             best_valid_ff, best_valid_in;
   logic [7:0]       best_slice_ff, best_slice_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [31:0]      now_ff, now_in;
   logic             idx_ok_ff, idx_ok_in;
   res_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_data_ff, rsp_data_in;

   // table RAM
   entry_type        mem [NUM_TASKS];
   logic [NUM_TASKS-1:0] valid_ff;
   entry_type        mem_rd_ff;
   logic             vld_rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_en;
   entry_type        wr_data;
   logic             rd_bypass;

   // datapath
   logic [AW-1:0]    idx_wide;
   logic             idx_ok;
   logic [IDX_W-1:0] idx_addr;
   entry_type        eff;
   entry_type        upd;
   logic             cand;
   logic             bv_nx;
   logic [7:0]       bs_nx;
   logic [IDX_W-1:0] bi_nx;
   logic [AW-1:0]    who_wide;

   assign idx_wide  = AW'(req_index);
   assign idx_ok    = idx_wide < AW'(NUM_TASKS);
   assign idx_addr  = idx_wide[IDX_W-1:0];
   assign eff       = vld_rd_ff ? mem_rd_ff : ENTRY_RESET;
   assign who_wide  = AW'(best_idx_ff);
   // a fetch of the entry being written this cycle sees the new contents
   assign rd_bypass = wr_en && (wr_addr == rd_addr);

   // shared entry unit: alarm, wake-up, recompute and best-counter compare
   always_comb begin
      upd = eff;
      if (eff.present) begin
         if (!recalc_ff) begin
            if ((eff.alarm != 32'd0) && (eff.alarm < now_ff)) begin
               upd.pending = eff.pending | SIG_ALRM_BIT;
               upd.alarm   = 32'd0;
            end
            if ((eff.run_state == RS_INTERRUPTIBLE) &&
                ((upd.pending & ~(eff.blocked & ~UNBLOCKABLE)) != 32'd0)) begin
               upd.run_state = RS_RUNNING;
            end
         end else begin
            upd.slice = {1'b0, eff.slice[7:1]} + {1'b0, eff.prio};
         end
      end
      cand = upd.present && (upd.run_state == RS_RUNNING) &&
             (!best_valid_ff || (upd.slice > best_slice_ff));
      bv_nx = best_valid_ff | cand;
      bs_nx = cand ? upd.slice : best_slice_ff;
      bi_nx = cand ? cur_ff : best_idx_ff;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      recalc_in     = recalc_ff;
      best_valid_in = best_valid_ff;
      best_slice_in = best_slice_ff;
      best_idx_in   = best_idx_ff;
      now_in        = now_ff;
      idx_ok_in     = idx_ok_ff;
      res_in        = res_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = upd;
      req_tready    = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               res_in = '0;
               case (req_tuser)
                  OP_WRITE: begin
                     wr_en    = idx_ok;
                     wr_addr  = idx_addr;
                     wr_data  = req_entry;
                     state_in = S_DONE;
                  end
                  OP_READ: begin
                     rd_addr   = idx_ok ? idx_addr : '0;
                     idx_ok_in = idx_ok;
                     state_in  = S_READ;
                  end
                  OP_SCHED: begin
                     rd_addr       = TOP_IDX;
                     cur_in        = TOP_IDX;
                     recalc_in     = 1'b0;
                     best_valid_in = 1'b0;
                     now_in        = req_now;
                     state_in      = S_PASS;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            if (idx_ok_ff) begin
               res_in.read_state   = eff.run_state;
               res_in.read_slice   = eff.slice;
               res_in.read_pending = eff.pending;
            end
            state_in = S_DONE;
         end
         S_PASS: begin
            wr_en         = 1'b1;
            best_valid_in = bv_nx;
            best_slice_in = bs_nx;
            best_idx_in   = bi_nx;
            if (cur_ff != ONE_IDX) begin
               rd_addr = cur_ff - ONE_IDX;
               cur_in  = cur_ff - ONE_IDX;
            end else if (!recalc_ff && bv_nx && (bs_nx == 8'd0)) begin
               // every runnable counter spent: second walk recomputes
               rd_addr       = TOP_IDX;
               cur_in        = TOP_IDX;
               recalc_in     = 1'b1;
               best_valid_in = 1'b0;
            end else begin
               // task 0 is never written during a walk, safe to fetch now
               rd_addr  = '0;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            res_in              = '0;
            res_in.next_task    = best_valid_ff ? who_wide[TASK_W-1:0] : '0;
            res_in.chosen_slice = best_valid_ff ? best_slice_ff : eff.slice;
            res_in.recalculated = recalc_ff;
            state_in            = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // table RAM, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_rd_ff <= rd_bypass ? wr_data : mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         vld_rd_ff <= rd_bypass | valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      recalc_ff     <= recalc_in;
      best_valid_ff <= best_valid_in;
      best_slice_ff <= best_slice_in;
      best_idx_ff   <= best_idx_in;
      now_ff        <= now_in;
      idx_ok_ff     <= idx_ok_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

endmodule

### tb/cpts_checker.sv
module cpts_checker #(
   parameter int NUM_TASKS = cpts_pkg::NUM_TASKS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [159:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [63:0]  rsp_tdata,
   output int           fail_count,
   output int           outstanding,
   output int           recalc_count
);
   import cpts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   entry_type task_tab [NUM_TASKS];
   res_type   pending_results [$];
   int        fails;
   int        recalcs;

   // highest counter among running tasks 1..N-1, ties to the higher index
   task automatic pick_highest(output int best, output int who);
      best = -1;
      who  = 0;
      for (int i = NUM_TASKS - 1; i >= 1; i--) begin
         if (task_tab[i].present && task_tab[i].run_state == RS_RUNNING &&
             int'(task_tab[i].slice) > best) begin
            best = int'(task_tab[i].slice);
            who  = i;
         end
      end
   endtask

   task automatic schedule_outcome(input logic [1:0] op, input logic [159:0] d,
                                   output res_type r);
      int         idx;
      logic [31:0] now;
      int         best;
      int         who;
      logic       redo;
      r    = '0;
      idx  = int'(d[5:0]);
      now  = d[152:121];
      redo = 1'b0;
      case (op)
         OP_WRITE: begin
            if (idx < NUM_TASKS) begin
               task_tab[idx].present   = d[6];
               task_tab[idx].run_state = d[9:7];
               task_tab[idx].slice     = d[17:10];
               task_tab[idx].prio      = d[24:18];
               task_tab[idx].alarm     = d[56:25];
               task_tab[idx].pending   = d[88:57];
               task_tab[idx].blocked   = d[120:89];
            end
         end
         OP_READ: begin
            if (idx < NUM_TASKS) begin
               r.read_state   = task_tab[idx].run_state;
               r.read_slice   = task_tab[idx].slice;
               r.read_pending = task_tab[idx].pending;
            end
         end
         OP_SCHED: begin
            for (int i = NUM_TASKS - 1; i >= 1; i--) begin
               if (task_tab[i].present) begin
                  if (task_tab[i].alarm != 32'd0 && task_tab[i].alarm < now) begin
                     task_tab[i].pending |= SIG_ALRM_BIT;
                     task_tab[i].alarm    = 32'd0;
                  end
                  if (task_tab[i].run_state == RS_INTERRUPTIBLE &&
                      (task_tab[i].pending &
                       ~(task_tab[i].blocked & ~UNBLOCKABLE)) != 32'd0)
                     task_tab[i].run_state = RS_RUNNING;
               end
            end
            pick_highest(best, who);
            if (best == 0) begin
               // all runnable counters spent: halve and add priority, one pass only
               redo = 1'b1;
               for (int i = NUM_TASKS - 1; i >= 1; i--) begin
                  if (task_tab[i].present)
                     task_tab[i].slice = {1'b0, task_tab[i].slice[7:1]} +
                                         {1'b0, task_tab[i].prio};
               end
               pick_highest(best, who);
            end
            r.next_task    = who[5:0];
            r.chosen_slice = task_tab[who].slice;
            r.recalculated = redo;
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fails++;
         if (fails <= 10)
            $display("checker: %s differs, expected %0h got %0h at %0t", name, want, got,
                     $realtime);
      end
   endtask

   always @(posedge clock) begin
      res_type got;
      res_type want;
      res_type predicted;
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++)
            task_tab[i] = ENTRY_RESET;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = res_type'(rsp_tdata[$bits(res_type)-1:0]);
            if (pending_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("checker: response beat %0h with nothing outstanding at %0t",
                           rsp_tdata, $realtime);
            end else begin
               want = pending_results.pop_front();
               check_field("next_task", 32'(want.next_task), 32'(got.next_task));
               check_field("chosen_slice", 32'(want.chosen_slice), 32'(got.chosen_slice));
               check_field("recalculated", 32'(want.recalculated), 32'(got.recalculated));
               check_field("read_state", 32'(want.read_state), 32'(got.read_state));
               check_field("read_slice", 32'(want.read_slice), 32'(got.read_slice));
               check_field("read_pending", want.read_pending, got.read_pending);
            end
         end
         if (req_tvalid && req_tready) begin
            schedule_outcome(req_tuser, req_tdata, predicted);
            if (predicted.recalculated)
               recalcs++;
            pending_results.push_back(predicted);
         end
      end
      fail_count   <= fails;
      outstanding  <= pending_results.size();
      recalc_count <= recalcs;
   end

endmodule

### tb/tb_top.sv
module tb_top;
   import cpts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1800;
   // slowest beat: full walk plus recompute, worst gap and stall; taken ~4x over
   localparam int CYCLE_LIMIT  = 1_200_000;
   localparam int SETTLE       = 2 * NUM_TASKS_DEF + 8;
   localparam int HOLD_CYCLES  = 400;

   // codes the package leaves out
   localparam logic [1:0] OP_UNDEF           = 2'd3;
   localparam logic [2:0] RS_UNINTERRUPTIBLE = 3'd2;
   localparam logic [2:0] RS_ZOMBIE          = 3'd3;
   localparam logic [2:0] RS_STOPPED         = 3'd4;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;

   int fail_count;
   int outstanding;
   int recalc_count;

   // stimulus bookkeeping
   int          n_items;
   int          n_write, n_sched, n_read, n_undef;
   int          burst_left;
   bit          steady;
   int          holds_asked, holds_served;
   int unsigned tick;
   int          win_base, win_size;
   int          cycles;

   always #5 clock = ~clock;

   counter_priority_task_scheduler_core #(
      .NUM_TASKS (NUM_TASKS_DEF)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cpts_checker #(
      .NUM_TASKS (NUM_TASKS_DEF)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .recalc_count (recalc_count)
   );

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("counter_priority_task_scheduler_core: mismatch");
         $finish;
      end
   end

   // receiver: segments of steady, random, sparse and periodic ready, plus long hold-offs on request
   initial begin : receiver
      int stall_left;
      int seg_left;
      int seg_mode;
      int phase;
      stall_left = 0;
      seg_left   = 0;
      seg_mode   = 0;
      phase      = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (holds_served != holds_asked) begin
            holds_served++;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(5, 80);
               seg_mode = $urandom_range(0, 3);
            end
            seg_left--;
            case (seg_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (phase % 3 != 0);
            endcase
         end
      end
   end

   // one request beat; valid stays up across back-to-back beats
   task automatic issue(input logic [1:0] op, input logic [5:0] idx, input logic pres,
                        input logic [2:0] rs, input logic [7:0] sl, input logic [6:0] pr,
                        input logic [31:0] al, input logic [31:0] pe,
                        input logic [31:0] bl, input logic [31:0] nw);
      req_tuser  <= op;
      req_tdata  <= {7'd0, nw, bl, pe, al, pr, sl, rs, pres, idx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      n_items++;
      case (op)
         OP_WRITE: n_write++;
         OP_SCHED: n_sched++;
         OP_READ:  n_read++;
         default:  n_undef++;
      endcase
      if (!steady) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 30);
         end else begin
            burst_left--;
         end
      end
   endtask

   // sender pause until every response is home; status is registered, hence the first wait
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // mode 0: live window task, 1: stray entry, mostly absent, 2: sweep clearing presence
   task automatic rand_write(input int idx, input int mode);
      logic       pres;
      logic [2:0] rs;
      logic [7:0] sl;
      logic [6:0] pr;
      logic [31:0] al, pe, bl;
      int         pick;
      case (mode)
         0:       pres = ($urandom_range(0, 9) != 0);
         1:       pres = ($urandom_range(0, 3) == 0);
         default: pres = 1'b0;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 45)      rs = RS_RUNNING;
      else if (pick < 75) rs = RS_INTERRUPTIBLE;
      else                rs = 3'($urandom_range(2, 7));
      pick = $urandom_range(0, 9);
      if (pick < 5)       sl = 8'd0;
      else if (pick < 8)  sl = 8'($urandom_range(0, 7));
      else                sl = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 19);
      if (pick == 0)      pr = 7'd0;
      else if (pick < 12) pr = 7'($urandom_range(1, 8));
      else                pr = 7'($urandom_range(1, 127));
      pick = $urandom_range(0, 9);
      if (pick < 4)       al = 32'd0;
      else if (pick < 8)  al = tick + $urandom_range(0, 20);
      else                al = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 4)       pe = 32'd0;
      else if (pick < 8)  pe = 32'd1 << $urandom_range(0, 31);
      else                pe = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 4)       bl = 32'd0;
      else if (pick < 7)  bl = $urandom;
      else                bl = '1;
      issue(OP_WRITE, idx[5:0], pres, rs, sl, pr, al, pe, bl, $urandom);
   endtask

   function automatic int pick_index();
      if ($urandom_range(0, 4) == 0)
         return $urandom_range(0, NUM_TASKS_DEF - 1);
      return win_base + $urandom_range(0, win_size - 1);
   endfunction

   task automatic rand_item();
      int          sel;
      int          idx;
      logic [31:0] nw;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         idx = pick_index();
         rand_write(idx, (idx >= win_base && idx < win_base + win_size) ? 0 : 1);
      end else if (sel < 80) begin
         tick += $urandom_range(0, 12);
         sel = $urandom_range(0, 19);
         if (sel < 17)       nw = tick;
         else if (sel < 19)  nw = $urandom;
         else                nw = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
         // unused fields carry noise: the block must ignore them
         issue(OP_SCHED, 6'($urandom), 1'($urandom), 3'($urandom), 8'($urandom),
               7'($urandom), $urandom, $urandom, $urandom, nw);
      end else if (sel < 95) begin
         issue(OP_READ, 6'(pick_index()), 1'($urandom), 3'($urandom), 8'($urandom),
               7'($urandom), $urandom, $urandom, $urandom, $urandom);
      end else begin
         issue(OP_UNDEF, 6'($urandom), 1'($urandom), 3'($urandom), 8'($urandom),
               7'($urandom), $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin : stimulus
      int episode;
      n_items      = 0;
      n_write      = 0;
      n_sched      = 0;
      n_read       = 0;
      n_undef      = 0;
      burst_left   = 0;
      steady       = 1'b0;
      holds_asked  = 0;
      tick         = $urandom_range(0, 1000);
      win_base     = 1;
      win_size     = 8;
      episode      = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // reset contents, then a decision on an empty table picks task zero
      issue(OP_READ,  6'd0,  0, RS_RUNNING, 0, 0, 0, 0, 0, 0);
      issue(OP_READ,  6'd63, 0, RS_RUNNING, 0, 0, 0, 0, 0, 0);
      issue(OP_SCHED, 6'd0,  0, RS_RUNNING, 0, 0, 0, 0, 0, 32'd0);
      // undefined opcode with every field bit set
      issue(OP_UNDEF, 6'd63, 1, 3'd7, 8'hFF, 7'h7F, '1, '1, '1, '1);
      // extremes in the top entry
      issue(OP_WRITE, 6'd63, 1, RS_RUNNING, 8'd255, 7'd127, '1, '1, '1, 0);
      issue(OP_READ,  6'd63, 0, RS_RUNNING, 0, 0, 0, 0, 0, 0);
      // task zero: runnable and with an old alarm, yet never touched or picked
      issue(OP_WRITE, 6'd0,  1, RS_RUNNING, 8'd200, 7'd127, 32'd5, '1, 32'd0, 0);
      // kill pending under a full block mask still wakes
      issue(OP_WRITE, 6'd5,  1, RS_INTERRUPTIBLE, 8'd0, 7'd0, 0, 32'h0000_0100, '1, 0);
      // blocked pending signal keeps the task asleep
      issue(OP_WRITE, 6'd6,  1, RS_INTERRUPTIBLE, 8'd9, 7'd3, 0, 32'h0000_0008,
            32'h0000_0008, 0);
      // alarm before now fires and wakes, alarm equal to now does not
      issue(OP_WRITE, 6'd7,  1, RS_INTERRUPTIBLE, 8'd0, 7'd0, 32'd100, 0, 0, 0);
      issue(OP_WRITE, 6'd8,  1, RS_INTERRUPTIBLE, 8'd12, 7'd2, 32'd101, 0, 0, 0);
      issue(OP_SCHED, 6'd0,  0, RS_RUNNING, 0, 0, 0, 0, 0, 32'd101);
      issue(OP_READ,  6'd7,  0, RS_RUNNING, 0, 0, 0, 0, 0, 0);
      issue(OP_READ,  6'd8,  0, RS_RUNNING, 0, 0, 0, 0, 0, 0);
      issue(OP_READ,  6'd6,  0, RS_RUNNING, 0, 0, 0, 0, 0, 0);
      // retire the top task: only zero counters at zero priority remain runnable
      issue(OP_WRITE, 6'd63, 0, RS_RUNNING, 8'd0, 7'd1, 0, 0, 0, 0);
      issue(OP_SCHED, 6'd0,  0, RS_RUNNING, 0, 0, 0, 0, 0, 32'd101);
      // equal counters go to the higher index; latest tick expires the last alarm
      issue(OP_WRITE, 6'd9,  1, RS_RUNNING, 8'd20, 7'd1, 0, 0, 0, 0);
      issue(OP_WRITE, 6'd10, 1, RS_RUNNING, 8'd20, 7'd1, 0, 0, 0, 0);
      issue(OP_SCHED, 6'd0,  0, RS_RUNNING, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
      // states that never run, including an unassigned code
      issue(OP_WRITE, 6'd10, 1, RS_STOPPED, 8'd240, 7'd1, 0, 0, 0, 0);
      issue(OP_WRITE, 6'd11, 1, 3'd7, 8'd250, 7'd9, 0, '1, 0, 0);
      issue(OP_WRITE, 6'd12, 1, RS_UNINTERRUPTIBLE, 8'd230, 7'd5, 0, '1, 0, 0);
      issue(OP_WRITE, 6'd13, 1, RS_ZOMBIE, 8'd220, 7'd5, 0, '1, 0, 0);
      issue(OP_READ,  6'd11, 0, RS_RUNNING, 0, 0, 0, 0, 0, 0);
      issue(OP_SCHED, 6'd0,  0, RS_RUNNING, 0, 0, 0, 0, 0, 32'd0);
      drain();

      // ---- random part: episodes around a small window of live tasks ----
      while (n_items < RANDOM_ITEMS + 26) begin
         episode++;
         if ($urandom_range(0, 9) == 0) begin
            // clear presence everywhere so counters can run dry again
            for (int i = 0; i < NUM_TASKS_DEF; i++)
               rand_write(i, 2);
         end
         win_base = $urandom_range(1, NUM_TASKS_DEF - 8);
         win_size = $urandom_range(2, 8);
         if (episode == 1 || $urandom_range(0, 5) == 0) begin
            // long receiver hold-off while the sender keeps offering beats
            holds_asked++;
            steady = 1'b1;
         end
         repeat ($urandom_range(20, 60)) rand_item();
         steady = 1'b0;
         if (episode == 2 || $urandom_range(0, 4) == 0)
            drain();
      end

      drain();
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d beats: %0d writes, %0d decisions, %0d reads, %0d undefined",
               n_items, n_write, n_sched, n_read, n_undef);
      $display("%0d decisions recomputed counters; %0d long receiver hold-offs",
               recalc_count, holds_asked);
      if (fail_count == 0 && outstanding == 0) begin
         $display("counter_priority_task_scheduler_core: match");
      end else begin
         $display("counter_priority_task_scheduler_core: mismatch");
      end
      $finish;
   end

endmodule

### counter_priority_task_scheduler_core.f
rtl/cpts_pkg.sv
rtl/counter_priority_task_scheduler_core.sv
tb/cpts_checker.sv
tb/tb_top.sv
